// ===== rtl/core/ost_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_pkg
// Shared types and constants for the order state table: entry layouts,
// operation and status codes, and the result record.
// ----------------------------------------------------------------------------
package ost_pkg;

  // Size of the order table. Index 0 is never handed out, and indices stop
  // at 255 because the order index field is eight bits wide.
  localparam int TABLE_ENTRIES = 256;
  localparam int ID_LIMIT      = (TABLE_ENTRIES < 256) ? TABLE_ENTRIES : 256;
  localparam int IDX_W         = (ID_LIMIT > 1) ? $clog2(ID_LIMIT) : 1;
  localparam int NEXT_W        = IDX_W + 1;
  localparam int ID_W          = 8;
  localparam int QTY_W         = 31;
  localparam int PRICE_W       = 32;
  localparam int SYM_W         = 16;
  localparam int KIND_W        = 2;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_CANCEL = 2'd1,
    OP_EXEC   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_PENDING   = 2'd0,
    ST_PARTIAL   = 2'd1,
    ST_FILLED    = 2'd2,
    ST_CANCELLED = 2'd3
  } status_t;

  // Fields that are fixed once an order is submitted.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [QTY_W-1:0]  qty;
    logic              side;
    logic [SYM_W-1:0]  sym;
  } static_t;

  // Fields that change as the order is worked.
  typedef struct packed {
    status_t          status;
    logic [QTY_W-1:0] filled;
  } progress_t;

  // Write request into the entry memories.
  typedef struct packed {
    logic             wr_entry;
    logic             wr_progress;
    logic [IDX_W-1:0] addr;
    static_t          stat;
    logic [PRICE_W-1:0] price;
    progress_t        prog;
  } entry_wr_t;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    result_id;
    logic [1:0]         status;
    logic [QTY_W-1:0]   filled;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
    logic [SYM_W-1:0]   sym;
    logic               side;
    logic [KIND_W-1:0]  kind;
    logic               status_report;
    logic               execution_report;
  } result_t;

endpackage

// ===== rtl/core/order_state_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_state_table
// Table of orders addressed by a sequential index, with submit, cancel,
// execution report and query operations.
// ----------------------------------------------------------------------------
// Each beat on the input channel carries one operation and produces exactly
// one result beat. An operation first reads the addressed entry from the
// synchronous entry memories, then updates it, writes it back and loads the
// output register. The next input beat is held off until that write-back
// has happened, so the block never takes a new item before it is through
// with the last one; a result waiting in the output register stalls input
// only while it is itself stalled.
// Entry presence is kept in flip-flop valid bits cleared by reset, so the
// block is ready in the cycle after reset with no memory clearing pass.
module order_state_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    operation,
  input  logic [ost_pkg::ID_W-1:0]      order_id,
  input  logic [ost_pkg::SYM_W-1:0]     symbol_code,
  input  logic                          is_buy,
  input  logic [ost_pkg::PRICE_W-1:0]   price,
  input  logic [ost_pkg::QTY_W-1:0]     quantity,
  input  logic [ost_pkg::KIND_W-1:0]    order_kind,
  input  logic [ost_pkg::QTY_W-1:0]     fill_quantity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [ost_pkg::ID_W-1:0]      result_id,
  output logic [1:0]                    order_status,
  output logic [ost_pkg::QTY_W-1:0]     filled_total,
  output logic [ost_pkg::QTY_W-1:0]     order_quantity,
  output logic [ost_pkg::PRICE_W-1:0]   order_price,
  output logic [ost_pkg::SYM_W-1:0]     order_symbol,
  output logic                          order_side,
  output logic [ost_pkg::KIND_W-1:0]    order_type_out,
  output logic                          status_report,
  output logic                          execution_report
);
  import ost_pkg::*;

  logic               accept;
  logic               busy;
  logic [NEXT_W-1:0]  next_index;
  logic [ID_LIMIT-1:0] valid_bits;

  op_t                op_q;
  logic [ID_W-1:0]    id_q;
  logic [SYM_W-1:0]   sym_q;
  logic               side_q;
  logic [PRICE_W-1:0] price_q;
  logic [QTY_W-1:0]   qty_q;
  logic [KIND_W-1:0]  kind_q;
  logic [QTY_W-1:0]   fill_q;

  static_t            rd_static;
  logic [PRICE_W-1:0] rd_price;
  progress_t          rd_progress;
  entry_wr_t          wr;
  result_t            res;
  result_t            res_q;

  logic               found;
  logic               full;

  assign accept   = in_valid && !in_stall;
  assign in_stall = busy || (out_valid && out_stall);

  assign full  = next_index >= NEXT_W'(ID_LIMIT);
  assign found = (id_q != '0) && (32'(id_q) < ID_LIMIT) && valid_bits[id_q[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      next_index <= NEXT_W'(1);
      valid_bits <= '0;
      out_valid  <= 1'b0;
    end else begin
      busy <= accept;
      if (busy) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr.wr_entry) begin
        valid_bits[wr.addr] <= 1'b1;
        next_index          <= next_index + NEXT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op_t'(operation);
      id_q    <= order_id;
      sym_q   <= symbol_code;
      side_q  <= is_buy;
      price_q <= price;
      qty_q   <= quantity;
      kind_q  <= order_kind;
      fill_q  <= fill_quantity;
    end
    if (busy) begin
      res_q <= res;
    end
  end

  ost_entry_store u_store (
    .clk         (clk),
    .rd_en       (accept),
    .rd_addr     (order_id[IDX_W-1:0]),
    .wr          (wr),
    .rd_static   (rd_static),
    .rd_price    (rd_price),
    .rd_progress (rd_progress)
  );

  ost_exec u_exec (
    .fire          (busy),
    .op            (op_q),
    .order_id      (id_q),
    .found         (found),
    .full          (full),
    .new_index     (next_index[IDX_W-1:0]),
    .symbol_code   (sym_q),
    .is_buy        (side_q),
    .price         (price_q),
    .quantity      (qty_q),
    .order_kind    (kind_q),
    .fill_quantity (fill_q),
    .rd_static     (rd_static),
    .rd_price      (rd_price),
    .rd_progress   (rd_progress),
    .wr            (wr),
    .res           (res)
  );

  assign ok               = res_q.ok;
  assign result_id        = res_q.result_id;
  assign order_status     = res_q.status;
  assign filled_total     = res_q.filled;
  assign order_quantity   = res_q.qty;
  assign order_price      = res_q.price;
  assign order_symbol     = res_q.sym;
  assign order_side       = res_q.side;
  assign order_type_out   = res_q.kind;
  assign status_report    = res_q.status_report;
  assign execution_report = res_q.execution_report;

  // The update stage is never occupied in consecutive cycles.
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("update stage held for more than one cycle");

  // While an item is in the update stage the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    busy |-> !out_valid)
    else $error("result register occupied during update");

  // A completed item always presents a result beat next.
  a_busy_to_out: assert property (@(posedge clk) disable iff (rst)
    busy |=> out_valid)
    else $error("completed item produced no result");

  // Allocation never runs past the last usable index.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    next_index <= NEXT_W'(ID_LIMIT) && next_index != '0)
    else $error("allocation index out of range");

  // Memory writes happen only in the update stage.
  a_write_gated: assert property (@(posedge clk) disable iff (rst)
    (wr.wr_entry || wr.wr_progress) |-> busy)
    else $error("entry write outside the update stage");

endmodule

// ===== rtl/core/ost_entry_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_entry_store
// Entry memories of the order table: static fields, price and progress,
// one synchronous read port and one write port, read data registered.
// ----------------------------------------------------------------------------
module ost_entry_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ost_pkg::IDX_W-1:0]     rd_addr,
  input  ost_pkg::entry_wr_t            wr,
  output ost_pkg::static_t              rd_static,
  output logic [ost_pkg::PRICE_W-1:0]   rd_price,
  output ost_pkg::progress_t            rd_progress
);
  import ost_pkg::*;

  static_t            static_mem   [ID_LIMIT];
  logic [PRICE_W-1:0] price_mem    [ID_LIMIT];
  progress_t          progress_mem [ID_LIMIT];

  always_ff @(posedge clk) begin
    if (wr.wr_entry) begin
      static_mem[wr.addr] <= wr.stat;
      price_mem[wr.addr]  <= wr.price;
    end
    if (wr.wr_entry || wr.wr_progress) begin
      progress_mem[wr.addr] <= wr.prog;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_static   <= static_mem[rd_addr];
      rd_price    <= price_mem[rd_addr];
      rd_progress <= progress_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/ost_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ost_exec
// Update logic: decides the outcome of one operation from the entry read
// back, forms the write-back and the result record.
// ----------------------------------------------------------------------------
module ost_exec (
  input  logic                          fire,
  input  ost_pkg::op_t                  op,
  input  logic [ost_pkg::ID_W-1:0]      order_id,
  input  logic                          found,
  input  logic                          full,
  input  logic [ost_pkg::IDX_W-1:0]     new_index,
  input  logic [ost_pkg::SYM_W-1:0]     symbol_code,
  input  logic                          is_buy,
  input  logic [ost_pkg::PRICE_W-1:0]   price,
  input  logic [ost_pkg::QTY_W-1:0]     quantity,
  input  logic [ost_pkg::KIND_W-1:0]    order_kind,
  input  logic [ost_pkg::QTY_W-1:0]     fill_quantity,
  input  ost_pkg::static_t              rd_static,
  input  logic [ost_pkg::PRICE_W-1:0]   rd_price,
  input  ost_pkg::progress_t            rd_progress,
  output ost_pkg::entry_wr_t            wr,
  output ost_pkg::result_t              res
);
  import ost_pkg::*;

  logic [QTY_W:0]   fill_sum;
  logic [QTY_W-1:0] fill_new;
  status_t          exec_status;
  static_t          new_static;
  progress_t        shown_prog;

  always_comb begin
    fill_sum = {1'b0, rd_progress.filled} + {1'b0, fill_quantity};
    fill_new = fill_sum[QTY_W] ? {QTY_W{1'b1}} : fill_sum[QTY_W-1:0];
    // A fill that leaves the total at zero keeps the old status, unless the order quantity is also zero.
    if (fill_new >= rd_static.qty) begin
      exec_status = ST_FILLED;
    end else if (fill_new != '0) begin
      exec_status = ST_PARTIAL;
    end else begin
      exec_status = rd_progress.status;
    end
  end

  always_comb begin
    new_static.kind = order_kind;
    new_static.qty  = quantity;
    new_static.side = is_buy;
    new_static.sym  = symbol_code;

    wr          = '0;
    wr.addr     = order_id[IDX_W-1:0];
    wr.stat     = new_static;
    wr.price    = price;
    wr.prog     = rd_progress;
    res         = '0;
    shown_prog  = rd_progress;

    case (op)
      OP_SUBMIT: begin
        if (!full) begin
          wr.wr_entry          = fire;
          wr.addr              = new_index;
          wr.prog.status       = ST_PENDING;
          wr.prog.filled       = '0;
          res.ok               = 1'b1;
          res.result_id        = ID_W'(new_index);
          res.status           = ST_PENDING;
          res.qty              = quantity;
          res.price            = price;
          res.sym              = symbol_code;
          res.side             = is_buy;
          res.kind             = order_kind;
          res.status_report    = 1'b1;
        end
      end
      default: begin
        res.result_id = order_id;
        if (found) begin
          case (op)
            OP_CANCEL: begin
              if (rd_progress.status != ST_FILLED &&
                  rd_progress.status != ST_CANCELLED) begin
                wr.wr_progress     = fire;
                wr.prog.status     = ST_CANCELLED;
                shown_prog.status  = ST_CANCELLED;
                res.ok             = 1'b1;
                res.status_report  = 1'b1;
              end
            end
            OP_EXEC: begin
              wr.wr_progress       = fire;
              wr.prog.status       = exec_status;
              wr.prog.filled       = fill_new;
              shown_prog.status    = exec_status;
              shown_prog.filled    = fill_new;
              res.ok               = 1'b1;
              res.status_report    = 1'b1;
              res.execution_report = 1'b1;
            end
            default: begin
              res.ok = 1'b1;
            end
          endcase
          res.status = shown_prog.status;
          res.filled = shown_prog.filled;
          res.qty    = rd_static.qty;
          res.price  = rd_price;
          res.sym    = rd_static.sym;
          res.side   = rd_static.side;
          res.kind   = rd_static.kind;
        end
      end
    endcase
  end

endmodule
